// ----- sv/quadrature_pid_position_drive_defines.svh -----
// Assertion macros for the quadrature PID position drive.
`ifndef QUADRATURE_PID_POSITION_DRIVE_DEFINES_SVH
`define QUADRATURE_PID_POSITION_DRIVE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define QPPD_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define QPPD_IMPLIES_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- sv/qppd_pkg.sv -----
// Shared types and constants for the quadrature PID position drive.
package qppd_pkg;

  localparam int POSITION_W    = 24;
  localparam int ERROR_W       = 25;
  localparam int GAIN_W        = 32;
  localparam int DUTY_W        = 10;
  localparam int TICK_W        = 16;
  localparam int SUM_W         = 48;
  localparam int ACC_W         = 48;
  localparam int FRACTION_BITS = 16;
  localparam int PROD_W        = GAIN_W + ERROR_W;
  localparam int WEIGHT_W      = TICK_W + ERROR_W;
  localparam int TOTAL_W       = PROD_W + 3;
  localparam int WHOLE_W       = ACC_W - FRACTION_BITS;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 3;

  localparam logic signed [POSITION_W-1:0] REFERENCE_RESET = 24'sd1736;
  localparam logic signed [GAIN_W-1:0]     GAIN_NOW_RESET   = 32'sd362411;
  localparam logic signed [GAIN_W-1:0]     GAIN_PREV_RESET  = -32'sd422813;
  localparam logic signed [GAIN_W-1:0]     GAIN_PREV2_RESET = 32'sd60403;
  localparam logic [DUTY_W-1:0]            PWM_RANGE_RESET  = 10'd100;
  localparam logic [TICK_W-1:0]            RUN_TICKS_RESET  = 16'd1000;

  typedef enum logic [1:0] {
    OP_EDGE_A = 2'd0,
    OP_EDGE_B = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REFERENCE  = 3'd0,
    REG_GAIN_NOW   = 3'd1,
    REG_GAIN_PREV  = 3'd2,
    REG_GAIN_PREV2 = 3'd3,
    REG_PWM_RANGE  = 3'd4,
    REG_RUN_TICKS  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       level_a;
    logic       level_b;
  } item_t;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [POSITION_W-1:0] position;
    logic signed [ERROR_W-1:0]    error;
    logic signed [PROD_W-1:0]     p_now;
    logic signed [PROD_W-1:0]     p_prev;
    logic signed [PROD_W-1:0]     p_prev2;
    logic [WEIGHT_W-1:0]          weight;
  } prod_t;

  typedef struct packed {
    logic signed [ERROR_W-1:0] last_error;
    logic signed [ERROR_W-1:0] older_error;
    logic [TICK_W-1:0]         tick_index;
  } hist_t;

  typedef struct packed {
    logic signed [POSITION_W-1:0] position;
    logic signed [ERROR_W-1:0]    error;
    logic [DUTY_W-1:0]            forward_duty;
    logic [DUTY_W-1:0]            reverse_duty;
    logic [SUM_W-1:0]             weighted_error_sum;
    logic                         finished;
  } result_t;

endpackage

// ----- sv/quadrature_pid_position_drive.sv -----
// Top level of the quadrature encoder PID position drive.
// Input channel (in_valid/in_ready) carries one request per encoder A edge,
// encoder B edge or sample tick, with the present levels of both channels.
// Output channel (out_valid/out_ready) returns exactly one result per
// request: position count, error, held forward and reverse duties, the
// weighted error sum and the finished flag.
// A result passes through the input register, the count/product register and
// the result register before out_valid rises. Throughput is one request per
// cycle while out_ready does not stall the output, set by the accumulator
// update in the loop stage.
// Registers are written through cfg_write/cfg_index/cfg_data; write them
// only while no request is in flight.
// Reset restores default register values, clears the count, the error
// history, the accumulator, the tick index, the error sum and the duties,
// and empties the pipeline.
// When a result waits with out_ready low the whole pipeline holds; in_ready
// drops only once the input register is also occupied.
`include "quadrature_pid_position_drive_defines.svh"

module quadrature_pid_position_drive (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [qppd_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [qppd_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               operation,
  input  logic                                     level_a,
  input  logic                                     level_b,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [qppd_pkg::POSITION_W-1:0]   position,
  output logic signed [qppd_pkg::ERROR_W-1:0]      error,
  output logic [qppd_pkg::DUTY_W-1:0]              forward_duty,
  output logic [qppd_pkg::DUTY_W-1:0]              reverse_duty,
  output logic [qppd_pkg::SUM_W-1:0]               weighted_error_sum,
  output logic                                     finished
);

  logic signed [qppd_pkg::POSITION_W-1:0] reference_counts;
  logic signed [qppd_pkg::GAIN_W-1:0]     gain_now;
  logic signed [qppd_pkg::GAIN_W-1:0]     gain_prev;
  logic signed [qppd_pkg::GAIN_W-1:0]     gain_prev2;
  logic [qppd_pkg::DUTY_W-1:0]            pwm_range;
  logic [qppd_pkg::TICK_W-1:0]            run_ticks;

  logic              adv;
  logic              s0_valid;
  logic              s1_valid;
  qppd_pkg::item_t   s0_item;
  qppd_pkg::prod_t   prod;
  qppd_pkg::hist_t   hist;
  qppd_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_counts <= qppd_pkg::REFERENCE_RESET;
      gain_now         <= qppd_pkg::GAIN_NOW_RESET;
      gain_prev        <= qppd_pkg::GAIN_PREV_RESET;
      gain_prev2       <= qppd_pkg::GAIN_PREV2_RESET;
      pwm_range        <= qppd_pkg::PWM_RANGE_RESET;
      run_ticks        <= qppd_pkg::RUN_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        qppd_pkg::REG_REFERENCE:  reference_counts <= cfg_data[qppd_pkg::POSITION_W-1:0];
        qppd_pkg::REG_GAIN_NOW:   gain_now         <= cfg_data[qppd_pkg::GAIN_W-1:0];
        qppd_pkg::REG_GAIN_PREV:  gain_prev        <= cfg_data[qppd_pkg::GAIN_W-1:0];
        qppd_pkg::REG_GAIN_PREV2: gain_prev2       <= cfg_data[qppd_pkg::GAIN_W-1:0];
        qppd_pkg::REG_PWM_RANGE:  pwm_range        <= cfg_data[qppd_pkg::DUTY_W-1:0];
        qppd_pkg::REG_RUN_TICKS:  run_ticks        <= cfg_data[qppd_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv || !s0_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item.op      <= operation;
      s0_item.level_a <= level_a;
      s0_item.level_b <= level_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  qppd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .load             (adv && s0_valid),
    .item             (s0_item),
    .reference_counts (reference_counts),
    .gain_now         (gain_now),
    .gain_prev        (gain_prev),
    .gain_prev2       (gain_prev2),
    .hist             (hist),
    .prod             (prod)
  );

  qppd_loop u_loop (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid     (s1_valid),
    .prod      (prod),
    .pwm_range (pwm_range),
    .run_ticks (run_ticks),
    .hist      (hist),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      position           <= result.position;
      error              <= result.error;
      forward_duty       <= result.forward_duty;
      reverse_duty       <= result.reverse_duty;
      weighted_error_sum <= result.weighted_error_sum;
      finished           <= result.finished;
    end
  end

  `QPPD_IMPLIES(a_finished_zero_duty, out_valid && finished, forward_duty == '0 && reverse_duty == '0, "duty driven after run end")
  `QPPD_IMPLIES(a_one_direction, out_valid, forward_duty == '0 || reverse_duty == '0, "both duties driven")
  `QPPD_IMPLIES(a_ready_only_on_stall, !in_ready, out_valid && !out_ready && s0_valid, "input stalled without output stall")
  `QPPD_IMPLIES_NEXT(a_no_phantom_result, out_valid && out_ready && !s1_valid, !out_valid, "result without request")

endmodule

// ----- sv/qppd_front.sv -----
// Encoder count, position error and gain products for one request.
module qppd_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  qppd_pkg::item_t                        item,
  input  logic signed [qppd_pkg::POSITION_W-1:0] reference_counts,
  input  logic signed [qppd_pkg::GAIN_W-1:0]     gain_now,
  input  logic signed [qppd_pkg::GAIN_W-1:0]     gain_prev,
  input  logic signed [qppd_pkg::GAIN_W-1:0]     gain_prev2,
  input  qppd_pkg::hist_t                        hist,
  output qppd_pkg::prod_t                        prod
);

  logic signed [qppd_pkg::POSITION_W-1:0] count;
  logic signed [qppd_pkg::POSITION_W-1:0] count_next;
  logic signed [qppd_pkg::ERROR_W-1:0]    err;
  logic [qppd_pkg::ERROR_W-1:0]           err_mag;
  logic [qppd_pkg::TICK_W-1:0]            tick_after;
  logic                                   up;

  always_comb begin
    up = 1'b0;
    count_next = count;
    case (item.op)
      qppd_pkg::OP_EDGE_A: begin
        up = (item.level_a == item.level_b);
        count_next = up ? count + qppd_pkg::POSITION_W'(1) : count - qppd_pkg::POSITION_W'(1);
      end
      qppd_pkg::OP_EDGE_B: begin
        up = (item.level_a != item.level_b);
        count_next = up ? count + qppd_pkg::POSITION_W'(1) : count - qppd_pkg::POSITION_W'(1);
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign err        = qppd_pkg::ERROR_W'(reference_counts) - qppd_pkg::ERROR_W'(count_next);
  assign err_mag    = err[qppd_pkg::ERROR_W-1] ? qppd_pkg::ERROR_W'(-err) : err;
  assign tick_after = hist.tick_index + qppd_pkg::TICK_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod.op       <= item.op;
      prod.position <= count_next;
      prod.error    <= err;
      prod.p_now    <= qppd_pkg::PROD_W'(gain_now) * qppd_pkg::PROD_W'(err);
      prod.p_prev   <= qppd_pkg::PROD_W'(gain_prev) * qppd_pkg::PROD_W'(hist.last_error);
      prod.p_prev2  <= qppd_pkg::PROD_W'(gain_prev2) * qppd_pkg::PROD_W'(hist.older_error);
      prod.weight   <= qppd_pkg::WEIGHT_W'(tick_after) * qppd_pkg::WEIGHT_W'(err_mag);
    end
  end

endmodule

// ----- sv/qppd_loop.sv -----
// Drive accumulator, duty selection, run length and weighted error sum.
module qppd_loop (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             valid,
  input  qppd_pkg::prod_t                  prod,
  input  logic [qppd_pkg::DUTY_W-1:0]      pwm_range,
  input  logic [qppd_pkg::TICK_W-1:0]      run_ticks,
  output qppd_pkg::hist_t                  hist,
  output qppd_pkg::result_t                result
);

  logic signed [qppd_pkg::ACC_W-1:0]   acc;
  logic signed [qppd_pkg::ACC_W-1:0]   acc_next;
  logic signed [qppd_pkg::ERROR_W-1:0] last_error;
  logic signed [qppd_pkg::ERROR_W-1:0] older_error;
  logic [qppd_pkg::TICK_W-1:0]         tick_index;
  logic [qppd_pkg::SUM_W-1:0]          error_sum;
  logic [qppd_pkg::SUM_W-1:0]          error_sum_next;
  logic [qppd_pkg::DUTY_W-1:0]         held_forward;
  logic [qppd_pkg::DUTY_W-1:0]         held_reverse;
  logic [qppd_pkg::DUTY_W-1:0]         held_forward_next;
  logic [qppd_pkg::DUTY_W-1:0]         held_reverse_next;

  logic                                over;
  logic                                take;
  logic signed [qppd_pkg::TOTAL_W-1:0] total;
  logic                                fits;
  logic signed [qppd_pkg::ACC_W-1:0]   acc_sat;
  logic [qppd_pkg::ACC_W-1:0]          acc_mag;
  logic [qppd_pkg::WHOLE_W-1:0]        whole;
  logic                                err_pos;
  logic [qppd_pkg::WHOLE_W-1:0]        duty_raw;
  logic [qppd_pkg::DUTY_W-1:0]         duty;
  logic [qppd_pkg::SUM_W:0]            sum_wide;

  assign over = (tick_index >= run_ticks);
  assign take = valid && (prod.op == qppd_pkg::OP_TICK) && !over;

  assign total = qppd_pkg::TOTAL_W'(acc) + qppd_pkg::TOTAL_W'(prod.p_now)
               + qppd_pkg::TOTAL_W'(prod.p_prev) + qppd_pkg::TOTAL_W'(prod.p_prev2);
  assign fits  = (&total[qppd_pkg::TOTAL_W-1:qppd_pkg::ACC_W-1])
               || !(|total[qppd_pkg::TOTAL_W-1:qppd_pkg::ACC_W-1]);

  always_comb begin
    if (fits) begin
      acc_sat = total[qppd_pkg::ACC_W-1:0];
    end else if (total[qppd_pkg::TOTAL_W-1]) begin
      acc_sat = {1'b1, {(qppd_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(qppd_pkg::ACC_W-1){1'b1}}};
    end
  end

  assign acc_mag = acc_sat[qppd_pkg::ACC_W-1] ? qppd_pkg::ACC_W'(-acc_sat) : acc_sat;
  assign whole   = acc_mag[qppd_pkg::ACC_W-1:qppd_pkg::FRACTION_BITS];
  assign err_pos = !prod.error[qppd_pkg::ERROR_W-1] && (prod.error != '0);

  always_comb begin
    if (err_pos) begin
      duty_raw = acc_sat[qppd_pkg::ACC_W-1] ? '0 : whole;
    end else begin
      duty_raw = acc_sat[qppd_pkg::ACC_W-1] ? whole : '0;
    end
    if (duty_raw > qppd_pkg::WHOLE_W'(pwm_range)) begin
      duty = pwm_range;
    end else begin
      duty = duty_raw[qppd_pkg::DUTY_W-1:0];
    end
  end

  assign sum_wide = {1'b0, error_sum} + (qppd_pkg::SUM_W + 1)'(prod.weight);

  always_comb begin
    held_forward_next = held_forward;
    held_reverse_next = held_reverse;
    acc_next          = acc;
    error_sum_next    = error_sum;
    hist.last_error   = last_error;
    hist.older_error  = older_error;
    hist.tick_index   = tick_index;
    if (valid && over) begin
      held_forward_next = '0;
      held_reverse_next = '0;
    end
    if (take) begin
      acc_next          = acc_sat;
      held_forward_next = err_pos ? duty : '0;
      held_reverse_next = err_pos ? '0 : duty;
      hist.last_error   = prod.error;
      hist.older_error  = last_error;
      hist.tick_index   = tick_index + qppd_pkg::TICK_W'(1);
      error_sum_next    = sum_wide[qppd_pkg::SUM_W] ? '1 : sum_wide[qppd_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      last_error   <= '0;
      older_error  <= '0;
      tick_index   <= '0;
      error_sum    <= '0;
      held_forward <= '0;
      held_reverse <= '0;
    end else if (en) begin
      acc          <= acc_next;
      last_error   <= hist.last_error;
      older_error  <= hist.older_error;
      tick_index   <= hist.tick_index;
      error_sum    <= error_sum_next;
      held_forward <= held_forward_next;
      held_reverse <= held_reverse_next;
    end
  end

  assign result.position           = prod.position;
  assign result.error              = prod.error;
  assign result.forward_duty       = held_forward_next;
  assign result.reverse_duty       = held_reverse_next;
  assign result.weighted_error_sum = error_sum_next;
  assign result.finished           = over;

endmodule

// ----- bench/quadrature_pid_position_drive_test.sv -----
// Self-checking testbench for the quadrature PID position drive.
module quadrature_pid_position_drive_test;
  import qppd_pkg::*;

  localparam int LATENCY = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_HI = 3'd7;
  localparam longint ERROR_TOP = (longint'(1) << (ERROR_W - 1)) - 1;
  localparam longint ERROR_BOTTOM = -(longint'(1) << (ERROR_W - 1));
  localparam longint ACC_TOP = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM = -(longint'(1) << (ACC_W - 1));
  localparam longint SUM_TOP = (longint'(1) << SUM_W) - 1;

  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  value;
    logic [1:0]             op;
    logic                   level_a;
    logic                   level_b;
    logic                   pinned;
    result_t                want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic level_a = 1'b0;
  logic level_b = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POSITION_W-1:0] position;
  logic signed [ERROR_W-1:0] error;
  logic [DUTY_W-1:0] forward_duty;
  logic [DUTY_W-1:0] reverse_duty;
  logic [SUM_W-1:0] weighted_error_sum;
  logic finished;

  logic pin_valid = 1'b0;
  result_t pin_result = '0;
  result_t awaited_reports[$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle = 11;
  int recv_idle = 54;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  logic signed [POSITION_W-1:0] reference_q = REFERENCE_RESET;
  logic signed [GAIN_W-1:0] gain_now_q = GAIN_NOW_RESET;
  logic signed [GAIN_W-1:0] gain_prev_q = GAIN_PREV_RESET;
  logic signed [GAIN_W-1:0] gain_prev2_q = GAIN_PREV2_RESET;
  logic [DUTY_W-1:0] pwm_range_q = PWM_RANGE_RESET;
  logic [TICK_W-1:0] run_ticks_q = RUN_TICKS_RESET;
  logic signed [POSITION_W-1:0] count_q = '0;
  logic signed [ERROR_W-1:0] last_err_q = '0;
  logic signed [ERROR_W-1:0] older_err_q = '0;
  logic signed [ACC_W-1:0] accumulator_q = '0;
  logic [TICK_W-1:0] tick_q = '0;
  logic [SUM_W-1:0] err_sum_q = '0;
  logic [DUTY_W-1:0] fwd_q = '0;
  logic [DUTY_W-1:0] rev_q = '0;

  quadrature_pid_position_drive uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .level_a(level_a),
    .level_b(level_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .position(position),
    .error(error),
    .forward_duty(forward_duty),
    .reverse_duty(reverse_duty),
    .weighted_error_sum(weighted_error_sum),
    .finished(finished)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [DUTY_W-1:0] duty_for(input longint whole);
    if (whole <= 0) return '0;
    if (whole > longint'(pwm_range_q)) return pwm_range_q;
    return whole[DUTY_W-1:0];
  endfunction

  task automatic advance_drive_model(input logic [1:0] op, input logic a, input logic b,
                                     output result_t report);
    logic over;
    logic climb;
    longint e;
    longint acc;
    longint whole;
    longint mag;
    longint add;
    over = (tick_q >= run_ticks_q);
    if (over) begin
      fwd_q = '0;
      rev_q = '0;
    end
    if (op == OP_EDGE_A || op == OP_EDGE_B) begin
      climb = (op == OP_EDGE_A) ? (a == b) : (a != b);
      count_q = climb ? count_q + 1'b1 : count_q - 1'b1;
    end
    e = longint'(reference_q) - longint'(count_q);
    if (e > ERROR_TOP) e = ERROR_TOP;
    if (e < ERROR_BOTTOM) e = ERROR_BOTTOM;
    if (op == OP_TICK && !over) begin
      acc = longint'(accumulator_q) + longint'(gain_now_q) * e
          + longint'(gain_prev_q) * longint'(last_err_q)
          + longint'(gain_prev2_q) * longint'(older_err_q);
      if (acc > ACC_TOP) acc = ACC_TOP;
      if (acc < ACC_BOTTOM) acc = ACC_BOTTOM;
      accumulator_q = acc[ACC_W-1:0];
      whole = acc / (longint'(1) << FRACTION_BITS);
      if (e > 0) begin
        fwd_q = duty_for(whole);
        rev_q = '0;
      end else begin
        rev_q = duty_for(-whole);
        fwd_q = '0;
      end
      older_err_q = last_err_q;
      last_err_q = e[ERROR_W-1:0];
      tick_q = tick_q + 1'b1;
      mag = (e < 0) ? -e : e;
      add = longint'(tick_q) * mag;
      if (SUM_TOP - longint'(err_sum_q) < add) err_sum_q = SUM_TOP[SUM_W-1:0];
      else err_sum_q = err_sum_q + add[SUM_W-1:0];
    end
    report = {count_q, e[ERROR_W-1:0], fwd_q, rev_q, err_sum_q, over};
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    if (mismatches < 10)
      $display("%s: position %0d/%0d error %0d/%0d fwd %0d/%0d rev %0d/%0d sum %0d/%0d fin %0b/%0b",
               what, $signed(want.position), $signed(got.position), $signed(want.error),
               $signed(got.error), want.forward_duty, got.forward_duty, want.reverse_duty,
               got.reverse_duty, want.weighted_error_sum, got.weighted_error_sum,
               want.finished, got.finished);
    mismatches++;
  endtask

  always @(posedge clk) begin : track_results
    result_t predicted;
    result_t observed;
    result_t awaited;
    if (!rst && in_valid && in_ready) begin
      advance_drive_model(operation, level_a, level_b, predicted);
      awaited_reports.push_back(pin_valid ? pin_result : predicted);
    end
    if (!rst && out_valid && out_ready) begin
      observed = {position, error, forward_duty, reverse_duty, weighted_error_sum, finished};
      if (awaited_reports.size() == 0) begin
        flag_mismatch("unrequested result", '0, observed);
      end else begin
        awaited = awaited_reports.pop_front();
        if (observed !== awaited) flag_mismatch("result mismatch (expected/actual)", awaited,
                                                observed);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic plan_row_t item_row(input logic [1:0] op, input logic a, input logic b);
    item_row = '0;
    item_row.op = op;
    item_row.level_a = a;
    item_row.level_b = b;
  endfunction

  function automatic plan_row_t pinned_row(input logic [1:0] op, input logic a, input logic b,
                                           input result_t want);
    pinned_row = item_row(op, a, b);
    pinned_row.pinned = 1'b1;
    pinned_row.want = want;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] value);
    write_row = '0;
    write_row.is_write = 1'b1;
    write_row.reg_index = index;
    write_row.value = value;
  endfunction

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_REFERENCE:  reference_q = value[POSITION_W-1:0];
      REG_GAIN_NOW:   gain_now_q = value;
      REG_GAIN_PREV:  gain_prev_q = value;
      REG_GAIN_PREV2: gain_prev2_q = value;
      REG_PWM_RANGE:  pwm_range_q = value[DUTY_W-1:0];
      REG_RUN_TICKS:  run_ticks_q = value[TICK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer_request(input logic [1:0] op, input logic a, input logic b,
                               input logic pin, input result_t want);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    operation <= op;
    level_a <= a;
    level_b <= b;
    pin_valid <= pin;
    pin_result <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  initial begin : stimulus
    plan_row_t directed_plan[$];
    logic [1:0] op;
    logic a;
    logic b;
    logic enc_a;
    logic enc_b;
    logic climb;
    logic [CFG_DATA_W-1:0] draw;
    int pick;
    int drift;
    int next_run;

    directed_plan.push_back(pinned_row(OP_EDGE_A, 1'b0, 1'b0,
                            {24'sd1, 25'sd1735, 10'd0, 10'd0, 48'd0, 1'b0}));
    directed_plan.push_back(pinned_row(OP_EDGE_B, 1'b0, 1'b1,
                            {24'sd2, 25'sd1734, 10'd0, 10'd0, 48'd0, 1'b0}));
    directed_plan.push_back(pinned_row(OP_EDGE_A, 1'b1, 1'b0,
                            {24'sd1, 25'sd1735, 10'd0, 10'd0, 48'd0, 1'b0}));
    directed_plan.push_back(pinned_row(OP_EDGE_B, 1'b1, 1'b1,
                            {24'sd0, 25'sd1736, 10'd0, 10'd0, 48'd0, 1'b0}));
    directed_plan.push_back(pinned_row(OP_UNUSED, 1'b1, 1'b1,
                            {24'sd0, 25'sd1736, 10'd0, 10'd0, 48'd0, 1'b0}));
    directed_plan.push_back(pinned_row(OP_TICK, 1'b0, 1'b0,
                            {24'sd0, 25'sd1736, 10'd100, 10'd0, 48'd1736, 1'b0}));
    directed_plan.push_back(item_row(OP_TICK, 1'b1, 1'b1));
    directed_plan.push_back(write_row(REG_PWM_RANGE, 32'h0000_03FF));
    directed_plan.push_back(write_row(REG_RUN_TICKS, 32'h5A5A_FFFF));
    directed_plan.push_back(write_row(REG_REFERENCE, 32'hA57F_FFFF));
    directed_plan.push_back(write_row(REG_GAIN_NOW, 32'h7FFF_FFFF));
    directed_plan.push_back(item_row(OP_TICK, 1'b0, 1'b1));
    directed_plan.push_back(item_row(OP_TICK, 1'b1, 1'b0));
    directed_plan.push_back(write_row(REG_REFERENCE, 32'h0080_0000));
    directed_plan.push_back(write_row(REG_GAIN_NOW, 32'h8000_0000));
    directed_plan.push_back(write_row(REG_GAIN_PREV, 32'h7FFF_FFFF));
    directed_plan.push_back(write_row(REG_GAIN_PREV2, 32'h8000_0000));
    directed_plan.push_back(item_row(OP_TICK, 1'b0, 1'b0));
    directed_plan.push_back(item_row(OP_EDGE_A, 1'b0, 1'b1));
    directed_plan.push_back(write_row(REG_PWM_RANGE, 32'hFFFF_FC00));
    directed_plan.push_back(item_row(OP_TICK, 1'b1, 1'b1));
    directed_plan.push_back(write_row(REG_RUN_TICKS, 32'hFFFF_0000));
    directed_plan.push_back(item_row(OP_TICK, 1'b0, 1'b0));
    directed_plan.push_back(item_row(OP_EDGE_B, 1'b1, 1'b0));
    directed_plan.push_back(item_row(OP_UNUSED, 1'b0, 1'b1));
    directed_plan.push_back(write_row(SPARE_REG_LO, 32'hDEAD_BEEF));
    directed_plan.push_back(write_row(SPARE_REG_HI, 32'h1234_5678));
    directed_plan.push_back(write_row(REG_REFERENCE, 32'h0000_0000));
    directed_plan.push_back(write_row(REG_PWM_RANGE, 32'h0000_0001));
    directed_plan.push_back(write_row(REG_GAIN_NOW, 32'h0001_0000));
    directed_plan.push_back(write_row(REG_GAIN_PREV, 32'hFFFF_0000));
    directed_plan.push_back(write_row(REG_GAIN_PREV2, 32'h0000_0000));
    directed_plan.push_back(write_row(REG_RUN_TICKS, 32'h0000_0001));
    directed_plan.push_back(item_row(OP_TICK, 1'b1, 1'b1));
    directed_plan.push_back(write_row(REG_RUN_TICKS, 32'h0000_FFFF));
    directed_plan.push_back(item_row(OP_TICK, 1'b0, 1'b0));
    directed_plan.push_back(item_row(OP_TICK, 1'b1, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        settle_pipeline();
        write_register(directed_plan[i].reg_index, directed_plan[i].value);
      end else begin
        offer_request(directed_plan[i].op, directed_plan[i].level_a, directed_plan[i].level_b,
                      directed_plan[i].pinned, directed_plan[i].want);
      end
    end

    enc_a = 1'b0;
    enc_b = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_pipeline();
      send_idle = (phase < 3) ? 11 : (phase < 6) ? 54 : 0;
      recv_idle = (phase < 3) ? 54 : (phase < 6) ? 11 : 0;

      draw = $urandom;
      if ($urandom_range(3) == 0) draw[POSITION_W-1:0] = POSITION_W'($urandom);
      else draw[POSITION_W-1:0] = POSITION_W'(int'(count_q) + int'($urandom_range(400)) - 200);
      write_register(REG_REFERENCE, draw);
      draw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(262143) - 131072;
      write_register(REG_GAIN_NOW, draw);
      draw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(262143) - 131072;
      write_register(REG_GAIN_PREV, draw);
      draw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(262143) - 131072;
      write_register(REG_GAIN_PREV2, draw);
      draw = $urandom;
      pick = $urandom_range(9);
      draw[DUTY_W-1:0] = (pick == 0) ? 10'd1 : (pick == 1) ? 10'd1023 :
                         DUTY_W'($urandom_range(1023, 1));
      write_register(REG_PWM_RANGE, draw);
      next_run = int'(tick_q) + $urandom_range(60);
      if (next_run > 65535 || $urandom_range(1) == 0) next_run = 65535;
      draw = $urandom;
      draw[TICK_W-1:0] = next_run[TICK_W-1:0];
      write_register(REG_RUN_TICKS, draw);

      drift = $urandom_range(70, 30);
      if (phase % 3 == 0) hold_req = ~hold_req;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase % 3 == 1 && n == ITEMS_PER_PHASE / 2) settle_pipeline();
        pick = $urandom_range(99);
        if (pick < 35) begin
          op = OP_TICK;
          a = enc_a;
          b = enc_b;
        end else if (pick < 38) begin
          op = OP_UNUSED;
          a = 1'($urandom_range(1));
          b = 1'($urandom_range(1));
        end else if (pick < 90) begin
          climb = ($urandom_range(99) < drift);
          if (climb == (enc_a != enc_b)) begin
            enc_a = ~enc_a;
            op = OP_EDGE_A;
          end else begin
            enc_b = ~enc_b;
            op = OP_EDGE_B;
          end
          a = enc_a;
          b = enc_b;
        end else begin
          op = $urandom_range(1) ? OP_EDGE_B : OP_EDGE_A;
          a = 1'($urandom_range(1));
          b = 1'($urandom_range(1));
        end
        offer_request(op, a, b, 1'b0, '0);
      end
    end

    settle_pipeline();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- quadrature_pid_position_drive.f -----
+incdir+sv
sv/qppd_pkg.sv
sv/qppd_front.sv
sv/qppd_loop.sv
sv/quadrature_pid_position_drive.sv
bench/quadrature_pid_position_drive_test.sv
